>>> design/lalt_pkg.sv
package lalt_pkg;

  localparam int ADDR_BITS_DEF = 48;
  localparam int CNT_BITS      = 16;
  localparam int NUM_TRK       = 3;
  localparam int TRK_BITS      = 2;
  localparam int Q_DEPTH       = 2;

  localparam logic [CNT_BITS-1:0] REPEAT_THRESHOLD_RST = CNT_BITS'(5);

  // operation kinds on the input beat
  localparam logic [1:0] FUNC_FIND   = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_ERASE  = 2'd2;
  localparam logic [1:0] FUNC_RESET  = 2'd3;

  // tracker slots
  localparam logic [TRK_BITS-1:0] TRK_FIND   = TRK_BITS'(0);
  localparam logic [TRK_BITS-1:0] TRK_INSERT = TRK_BITS'(1);

  typedef enum logic [1:0] {
    ACT_HIT,
    ACT_CLEAR,
    ACT_RESET_ALL
  } act_t;

  typedef struct packed {
    act_t                act;
    logic [TRK_BITS-1:0] trk;
    logic                is_ins;
    logic                app;
    logic                pre;
  } ctrl_t;

  localparam int CTRL_BITS = $bits(ctrl_t);

endpackage

>>> design/leaf_access_locality_tracker_core.sv
// Channel   Direction  Handshake             Payload
// in_*      input      in_valid / in_ready   func, succeeded, page_addr, slot, node_count,
//                                            has_left, has_right
// out_*     output     out_valid / out_ready hint addresses, hint flags, run counts
// cfg_*     input      cfg_we (no wait)      repeat threshold
//
// One beat per cycle sustained while out_ready stays high. With the queue empty, an accepted
// beat is written into the queue, then popped into the back-end registers, from which
// it leaves at the output.
// The tracker state update is address compares and saturating increments, fed back
// through the back-end state registers.
// Synchronous active-low reset; threshold resets to five, trackers to zero.
// A stalled output holds its beat and stops the back end; the two-entry queue takes one
// more input beat and then holds in_ready low until the output moves.
module leaf_access_locality_tracker_core #(
  parameter int ADDR_BITS = lalt_pkg::ADDR_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lalt_pkg::CNT_BITS-1:0] cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_func,
  input  logic                          in_succeeded,
  input  logic [ADDR_BITS-1:0]          in_page_addr,
  input  logic [lalt_pkg::CNT_BITS-1:0] in_slot,
  input  logic [lalt_pkg::CNT_BITS-1:0] in_node_count,
  input  logic                          in_has_left,
  input  logic                          in_has_right,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_find_fast_track,
  output logic [ADDR_BITS-1:0]          out_find_hint_addr,
  output logic [ADDR_BITS-1:0]          out_insert_hint_addr,
  output logic                          out_append_hint,
  output logic                          out_prepend_hint,
  output logic [lalt_pkg::CNT_BITS-1:0] out_append_run,
  output logic [lalt_pkg::CNT_BITS-1:0] out_prepend_run
);
  import lalt_pkg::*;

  localparam int QW = CTRL_BITS + ADDR_BITS;

  // front end: classification of the beat
  logic                 q_full, q_push, q_valid, q_pop;
  ctrl_t                f_ctrl, b_ctrl;
  logic [ADDR_BITS-1:0] f_addr, b_addr;
  logic [QW-1:0]        q_wdata, q_rdata;

  lalt_front #(
    .ADDR_BITS(ADDR_BITS)
  ) u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_succeeded  (in_succeeded),
    .in_page_addr  (in_page_addr),
    .in_slot       (in_slot),
    .in_node_count (in_node_count),
    .in_has_left   (in_has_left),
    .in_has_right  (in_has_right),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_ctrl        (f_ctrl),
    .q_addr        (f_addr)
  );

  // decoupling queue between the classifier and the tracker state
  assign q_wdata = {f_ctrl, f_addr};

  lalt_fifo #(
    .WIDTH(QW),
    .DEPTH(Q_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .rdata     (q_rdata)
  );

  assign b_ctrl = ctrl_t'(q_rdata[QW-1:ADDR_BITS]);
  assign b_addr = q_rdata[ADDR_BITS-1:0];

  // back end: tracker update and registered result
  lalt_back #(
    .ADDR_BITS(ADDR_BITS)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .q_valid              (q_valid),
    .q_pop                (q_pop),
    .q_ctrl               (b_ctrl),
    .q_addr               (b_addr),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_find_fast_track  (out_find_fast_track),
    .out_find_hint_addr   (out_find_hint_addr),
    .out_insert_hint_addr (out_insert_hint_addr),
    .out_append_hint      (out_append_hint),
    .out_prepend_hint     (out_prepend_hint),
    .out_append_run       (out_append_run),
    .out_prepend_run      (out_prepend_run)
  );

endmodule

>>> design/lalt_front.sv
module lalt_front #(
  parameter int ADDR_BITS = lalt_pkg::ADDR_BITS_DEF
) (
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_func,
  input  logic                          in_succeeded,
  input  logic [ADDR_BITS-1:0]          in_page_addr,
  input  logic [lalt_pkg::CNT_BITS-1:0] in_slot,
  input  logic [lalt_pkg::CNT_BITS-1:0] in_node_count,
  input  logic                          in_has_left,
  input  logic                          in_has_right,
  input  logic                          q_full,
  output logic                          q_push,
  output lalt_pkg::ctrl_t               q_ctrl,
  output logic [ADDR_BITS-1:0]          q_addr
);
  import lalt_pkg::*;

  logic [CNT_BITS-1:0] last_slot;

  assign in_ready  = !q_full;
  assign q_push    = in_valid && !q_full;
  assign q_addr    = in_page_addr;
  assign last_slot = in_node_count - CNT_BITS'(1);

  always_comb begin
    q_ctrl.trk    = TRK_BITS'(in_func);
    q_ctrl.is_ins = (in_func == FUNC_INSERT);
    // empty leaf never counts as an append
    q_ctrl.app    = !in_has_right && (in_node_count != '0) && (in_slot == last_slot);
    q_ctrl.pre    = !in_has_left && (in_slot == '0);
    case (in_func)
      FUNC_RESET: begin
        q_ctrl.act = ACT_RESET_ALL;
      end
      FUNC_FIND, FUNC_INSERT, FUNC_ERASE: begin
        q_ctrl.act = in_succeeded ? ACT_HIT : ACT_CLEAR;
      end
      default: begin
        q_ctrl.act = ACT_RESET_ALL;
      end
    endcase
  end

endmodule

>>> design/lalt_fifo.sv
module lalt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = lalt_pkg::Q_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] rdata
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  assign full      = (cnt_r == CW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign rdata     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

>>> design/lalt_back.sv
module lalt_back #(
  parameter int ADDR_BITS = lalt_pkg::ADDR_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lalt_pkg::CNT_BITS-1:0] cfg_wdata,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  lalt_pkg::ctrl_t               q_ctrl,
  input  logic [ADDR_BITS-1:0]          q_addr,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_find_fast_track,
  output logic [ADDR_BITS-1:0]          out_find_hint_addr,
  output logic [ADDR_BITS-1:0]          out_insert_hint_addr,
  output logic                          out_append_hint,
  output logic                          out_prepend_hint,
  output logic [lalt_pkg::CNT_BITS-1:0] out_append_run,
  output logic [lalt_pkg::CNT_BITS-1:0] out_prepend_run
);
  import lalt_pkg::*;

  logic [CNT_BITS-1:0]  thresh_r;
  logic [ADDR_BITS-1:0] leaf_r   [NUM_TRK];
  logic [ADDR_BITS-1:0] leaf_nxt [NUM_TRK];
  logic [CNT_BITS-1:0]  rpt_r    [NUM_TRK];
  logic [CNT_BITS-1:0]  rpt_nxt  [NUM_TRK];
  logic [CNT_BITS-1:0]  app_r, app_nxt;
  logic [CNT_BITS-1:0]  pre_r, pre_nxt;
  logic                 vld_r, vld_nxt;
  logic                 fft, ift;

  logic                 fft_r;
  logic [ADDR_BITS-1:0] fhint_r, ihint_r;

  function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] v);
    return (v == '1) ? v : v + CNT_BITS'(1);
  endfunction

  assign q_pop   = q_valid && (!vld_r || out_ready);
  assign vld_nxt = q_pop || (vld_r && !out_ready);

  always_comb begin
    for (int k = 0; k < NUM_TRK; k++) begin
      leaf_nxt[k] = leaf_r[k];
      rpt_nxt[k]  = rpt_r[k];
      if (q_ctrl.act == ACT_RESET_ALL) begin
        leaf_nxt[k] = '0;
        rpt_nxt[k]  = '0;
      end else if (q_ctrl.trk == TRK_BITS'(k)) begin
        if (q_ctrl.act == ACT_CLEAR) begin
          leaf_nxt[k] = '0;
          rpt_nxt[k]  = '0;
        end else if (leaf_r[k] != q_addr) begin
          leaf_nxt[k] = q_addr;
          rpt_nxt[k]  = '0;
        end else begin
          rpt_nxt[k]  = sat_inc(rpt_r[k]);
        end
      end
    end
    app_nxt = app_r;
    pre_nxt = pre_r;
    if (q_ctrl.is_ins) begin
      case (q_ctrl.act)
        ACT_HIT: begin
          app_nxt = q_ctrl.app ? sat_inc(app_r) : '0;
          pre_nxt = q_ctrl.pre ? sat_inc(pre_r) : '0;
        end
        ACT_CLEAR: begin
          app_nxt = '0;
          pre_nxt = '0;
        end
        default: begin
          app_nxt = app_r;
          pre_nxt = pre_r;
        end
      endcase
    end
    fft = (rpt_nxt[TRK_FIND] >= thresh_r);
    ift = (rpt_nxt[TRK_INSERT] >= thresh_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= REPEAT_THRESHOLD_RST;
      vld_r    <= 1'b0;
      app_r    <= '0;
      pre_r    <= '0;
      for (int k = 0; k < NUM_TRK; k++) begin
        leaf_r[k] <= '0;
        rpt_r[k]  <= '0;
      end
    end else begin
      vld_r <= vld_nxt;
      if (cfg_we) begin
        thresh_r <= cfg_wdata;
      end
      if (q_pop) begin
        app_r <= app_nxt;
        pre_r <= pre_nxt;
        for (int k = 0; k < NUM_TRK; k++) begin
          leaf_r[k] <= leaf_nxt[k];
          rpt_r[k]  <= rpt_nxt[k];
        end
      end
    end
  end

  // result register, loaded with the post-update view
  always_ff @(posedge clk) begin
    if (q_pop) begin
      fft_r   <= fft;
      fhint_r <= fft ? leaf_nxt[TRK_FIND] : '0;
      ihint_r <= ift ? leaf_nxt[TRK_INSERT] : '0;
    end
  end

  assign out_valid            = vld_r;
  assign out_find_fast_track  = fft_r;
  assign out_find_hint_addr   = fhint_r;
  assign out_insert_hint_addr = ihint_r;
  assign out_append_run       = app_r;
  assign out_prepend_run      = pre_r;
  assign out_append_hint      = (app_r != '0);
  assign out_prepend_hint     = (app_r == '0) && (pre_r != '0);

endmodule
